// ===== sv/pcs_pkg.sv =====
// shared types and constants of the phase current sense block
`default_nettype none

package pcs_pkg;

  localparam int unsigned SampleBits = 12;
  localparam int unsigned OffW       = SampleBits + 4;
  localparam int unsigned ScaleW     = 24;
  localparam int unsigned CurW       = 32;
  localparam int unsigned ShiftQ     = 12;
  localparam int unsigned CfgAddrW   = 3;
  localparam int unsigned CfgDataW   = ScaleW;
  localparam logic [ScaleW-1:0] ScaleReset = 24'd4096;

  typedef enum logic [CfgAddrW-1:0] {
    CfgChannelMode = 3'd0,
    CfgSignPhaseA  = 3'd1,
    CfgSignPhaseB  = 3'd2,
    CfgSignPhaseC  = 3'd3,
    CfgCurrentScale = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [SampleBits-1:0] sample_a;
    logic [SampleBits-1:0] sample_b;
    logic [SampleBits-1:0] sample_c;
  } in_item_t;

  typedef struct packed {
    logic signed [CurW-1:0] current_a;
    logic signed [CurW-1:0] current_b;
    logic signed [CurW-1:0] current_c;
  } out_item_t;

  typedef logic [2:0][OffW-1:0] offsets_t;

  typedef struct packed {
    logic calibrating;
    logic running;
  } cal_stat_t;

endpackage

`default_nettype wire

// ===== sv/phase_current_sense_calibrated_core.sv =====
// top level of the calibrated phase current sense block
// path: an accepted request is registered in the input stage, then in the result stage
// throughput: one request per cycle unless the output stalls, with no gap when calibration ends
// calibration: the first CAL_SAMPLES requests give no result, offsets are
// taken in the cycle after the last of them while input stays ready
// reset: async active low, clears config to defaults and restarts calibration
`default_nettype none

module phase_current_sense_calibrated_core #(
  parameter int unsigned CAL_SAMPLES = 1000
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire pcs_pkg::in_item_t      in_data_i,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output pcs_pkg::out_item_t          out_data_o,
  input  wire                         cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire [pcs_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  wire [pcs_pkg::CfgDataW-1:0] cfg_data_i
);

  // configuration registers
  logic                        mode_q;
  logic                        neg_a_q;
  logic                        neg_b_q;
  logic                        neg_c_q;
  logic [pcs_pkg::ScaleW-1:0]  scale_q;

  // input stage and result stage
  pcs_pkg::in_item_t  s1_q;
  logic               s1_valid_q;
  pcs_pkg::out_item_t out_q;
  logic               out_valid_q;
  pcs_pkg::out_item_t out_d;

  pcs_pkg::cal_stat_t cal_stat;
  pcs_pkg::offsets_t  offsets;

  logic in_acc;
  logic s1_adv;
  logic logic_c_unused;
  logic signed [pcs_pkg::CurW-1:0] cur_c;

  // config writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      neg_a_q <= 1'b0;
      neg_b_q <= 1'b0;
      neg_c_q <= 1'b0;
      scale_q <= pcs_pkg::ScaleReset;
    end else if (cfg_valid_i) begin
      case (pcs_pkg::cfg_idx_e'(cfg_addr_i))
        pcs_pkg::CfgChannelMode:  mode_q  <= cfg_data_i[0];
        pcs_pkg::CfgSignPhaseA:   neg_a_q <= cfg_data_i[0];
        pcs_pkg::CfgSignPhaseB:   neg_b_q <= cfg_data_i[0];
        pcs_pkg::CfgSignPhaseC:   neg_c_q <= cfg_data_i[0];
        pcs_pkg::CfgCurrentScale: scale_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // result stage takes a new value when empty or being drained
  assign s1_adv = !out_valid_q || out_ready_i;

  // calibration requests go straight into the sums; later ones into the input stage
  assign in_ready_o = cal_stat.calibrating ||
                      (cal_stat.running && (!s1_valid_q || s1_adv));
  assign in_acc = in_valid_i && in_ready_o;

  pcs_calib #(
    .CAL_SAMPLES(CAL_SAMPLES)
  ) u_calib (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (in_acc && cal_stat.calibrating),
    .smp_i    (in_data_i),
    .mode_i   (mode_q),
    .stat_o   (cal_stat),
    .offsets_o(offsets)
  );

  pcs_scale u_scale_a (
    .sample_i (s1_q.sample_a),
    .offset_i (offsets[0]),
    .neg_i    (neg_a_q),
    .scale_i  (scale_q),
    .current_o(out_d.current_a)
  );

  pcs_scale u_scale_b (
    .sample_i (s1_q.sample_b),
    .offset_i (offsets[1]),
    .neg_i    (neg_b_q),
    .scale_i  (scale_q),
    .current_o(out_d.current_b)
  );

  pcs_scale u_scale_c (
    .sample_i (s1_q.sample_c),
    .offset_i (offsets[2]),
    .neg_i    (neg_c_q),
    .scale_i  (scale_q),
    .current_o(cur_c)
  );

  // phase c reads zero with two sensed phases
  assign logic_c_unused  = !mode_q;
  assign out_d.current_c = logic_c_unused ? '0 : cur_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc && cal_stat.running) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_valid_q && s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc && cal_stat.running) begin
      s1_q <= in_data_i;
    end
    if (s1_valid_q && s1_adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== sv/pcs_calib.sv =====
// start-up offset calibration: per-channel sums and a reciprocal divide
`default_nettype none

module pcs_calib #(
  parameter int unsigned CAL_SAMPLES = 1000
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   acc_i,
  input  wire pcs_pkg::in_item_t smp_i,
  input  wire                   mode_i,
  output pcs_pkg::cal_stat_t    stat_o,
  output pcs_pkg::offsets_t     offsets_o
);

  localparam int unsigned CntW     = $clog2(CAL_SAMPLES + 1);
  localparam int unsigned SumW     = pcs_pkg::SampleBits + CntW;
  localparam int unsigned DivW     = SumW + 4;
  // reciprocal of the set count, exact for every dividend below 2**DivW
  localparam int unsigned RecShift = DivW + CntW;
  localparam int unsigned RecW     = DivW + 2;
  localparam int unsigned ProdW    = DivW + RecW;
  localparam logic [CntW-1:0] LastCnt = CntW'(CAL_SAMPLES - 1);
  localparam logic [RecW-1:0] Recip   =
    RecW'(((longint'(1) << RecShift) + longint'(CAL_SAMPLES) - 1) / longint'(CAL_SAMPLES));

  typedef enum logic [1:0] {
    StCal,
    StDiv,
    StRun
  } state_e;

  state_e             state_q;
  logic [CntW-1:0]    cnt_q;
  logic [SumW-1:0]    sum_q [3];
  logic [SumW-1:0]    sum_d [3];
  logic [ProdW-1:0]   prod [3];
  pcs_pkg::offsets_t  offs_q;
  logic [pcs_pkg::SampleBits-1:0] smp [3];

  assign smp[0] = smp_i.sample_a;
  assign smp[1] = smp_i.sample_b;
  assign smp[2] = smp_i.sample_c;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      // phase c only joins the sum while three phases are sensed
      if (k < 2 || mode_i) begin
        sum_d[k] = sum_q[k] + SumW'(smp[k]);
      end else begin
        sum_d[k] = sum_q[k];
      end
      // sum * 16 times the reciprocal, quotient sits above RecShift
      prod[k] = ProdW'({sum_q[k], 4'b0000}) * ProdW'(Recip);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StCal;
      cnt_q   <= '0;
      offs_q  <= '0;
      for (int k = 0; k < 3; k++) begin
        sum_q[k] <= '0;
      end
    end else begin
      case (state_q)
        StCal: begin
          if (acc_i) begin
            for (int k = 0; k < 3; k++) begin
              sum_q[k] <= sum_d[k];
            end
            cnt_q <= cnt_q + 1'b1;
            if (cnt_q == LastCnt) begin
              state_q <= StDiv;
            end
          end
        end
        StDiv: begin
          for (int k = 0; k < 3; k++) begin
            offs_q[k] <= prod[k][RecShift +: pcs_pkg::OffW];
          end
          state_q <= StRun;
        end
        StRun: begin
        end
        default: begin
          state_q <= StCal;
        end
      endcase
    end
  end

  assign offsets_o = offs_q;

  // offsets land no later than the edge that takes the first request after calibration
  assign stat_o.calibrating = (state_q == StCal);
  assign stat_o.running     = (state_q != StCal);

endmodule

`default_nettype wire

// ===== sv/pcs_scale.sv =====
// one phase: offset removal, polarity, scaling and saturation
`default_nettype none

module pcs_scale (
  input  wire [pcs_pkg::SampleBits-1:0] sample_i,
  input  wire [pcs_pkg::OffW-1:0]       offset_i,
  input  wire                           neg_i,
  input  wire [pcs_pkg::ScaleW-1:0]     scale_i,
  output logic signed [pcs_pkg::CurW-1:0] current_o
);

  localparam int unsigned DiffW = pcs_pkg::OffW + 2;
  localparam int unsigned ProdW = DiffW + pcs_pkg::ScaleW + 1;

  logic signed [DiffW-1:0] diff;
  logic signed [DiffW-1:0] diff_s;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] quo;
  logic [ProdW-pcs_pkg::CurW:0] top_bits;

  assign diff   = $signed({2'b00, sample_i, 4'b0000}) - $signed({2'b00, offset_i});
  assign diff_s = neg_i ? -diff : diff;
  assign prod   = diff_s * $signed({1'b0, scale_i});
  // arithmetic shift rounds toward minus infinity
  assign quo    = prod >>> pcs_pkg::ShiftQ;
  assign top_bits = quo[ProdW-1:pcs_pkg::CurW-1];

  always_comb begin
    if ((&top_bits) || !(|top_bits)) begin
      current_o = quo[pcs_pkg::CurW-1:0];
    end else if (quo[ProdW-1]) begin
      current_o = {1'b1, {(pcs_pkg::CurW-1){1'b0}}};
    end else begin
      current_o = {1'b0, {(pcs_pkg::CurW-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

// ===== sv/pcs_checker.sv =====
// port-level checks of the phase current sense block and their bind
`default_nettype none

module pcs_checker (
  input wire                     clk_i,
  input wire                     rst_ni,
  input wire                     in_valid_i,
  input wire                     in_ready_o,
  input wire                     out_valid_o,
  input wire                     out_ready_i,
  input wire pcs_pkg::out_item_t out_data_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // a result leaves only through a handshake
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i))
    else $error("result dropped without handshake");

  // a new result comes from a request taken earlier and held in the input stage
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without matching request");

  // with both stages full and the output stalled, input must back off
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i &&
    $past(in_valid_i && in_ready_o && out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input ready while pipeline is full");

endmodule

bind phase_current_sense_calibrated_core pcs_checker u_pcs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

`default_nettype wire

// ===== tb/phase_current_sense_calibrated_core_tb.sv =====
// testbench of the calibrated phase current sense block with its own current predictor
`timescale 1ns / 1ps

module phase_current_sense_calibrated_core_tb;
  import pcs_pkg::*;

  // offset calibration length, the block's own default
  localparam int unsigned CalSets     = 1000;
  localparam int unsigned TwoPhaseCal = 300;
  localparam int unsigned RoundSets   = 100;
  localparam int unsigned Rounds      = 6;
  // idle odds in percent, per side
  localparam int unsigned IdlePct     = 6;
  // cycles of quiet before a register write or the verdict
  localparam int unsigned SettleCycles = 40;
  // stretches with no idling, counted in requests sent and results seen
  localparam int unsigned TxCalmLo = 1250;
  localparam int unsigned TxCalmHi = 1400;
  localparam int unsigned RxCalmLo = 400;
  localparam int unsigned RxCalmHi = 520;
  // long receiver hold-off so that the block backs up into its input
  localparam int unsigned HoldAtResult = 130;
  localparam int unsigned HoldCycles   = 200;
  // register index that maps to nothing, the write must be harmless
  localparam logic [CfgAddrW-1:0] UnusedIdx = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  in_item_t            in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgAddrW-1:0] cfg_addr_i = CfgChannelMode;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  phase_current_sense_calibrated_core #(
    .CAL_SAMPLES(CalSets)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // sample sets waiting for the driver, and currents still owed by the block
  in_item_t  sets_pending[$];
  out_item_t currents_due[$];

  int unsigned items_sent    = 0;
  int unsigned currents_seen = 0;
  int unsigned errors        = 0;

  // predictor copy of the register file, reset values
  bit                three_phase = 1'b0;
  bit [2:0]          phase_neg   = 3'b000;
  logic [ScaleW-1:0] scale_q12   = ScaleReset;

  // predictor copy of the calibration state
  bit          cal_open = 1'b1;
  int unsigned cal_sets = 0;
  int unsigned code_sum[3]    = '{0, 0, 0};
  int unsigned code_offset[3] = '{0, 0, 0};

  wire tx_calm = items_sent >= TxCalmLo && items_sent < TxCalmHi;
  wire rx_calm = currents_seen >= RxCalmLo && currents_seen < RxCalmHi;

  task automatic flag_mismatch(string msg);
    errors++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  // sign * (code*16 - offset) * scale, floored shift by twelve, clamped to 32 bits
  function automatic logic signed [CurW-1:0] scaled_current(logic [SampleBits-1:0] code,
                                                            int unsigned offset, bit neg);
    longint diff;
    longint q;
    diff = longint'(code) * 16 - longint'(offset);
    if (neg) diff = -diff;
    q = (diff * longint'(scale_q12)) >>> ShiftQ;
    if (q > (longint'(1) <<< 31) - 1) q = (longint'(1) <<< 31) - 1;
    if (q < -(longint'(1) <<< 31)) q = -(longint'(1) <<< 31);
    return q[CurW-1:0];
  endfunction

  // one accepted request: accumulate while calibrating, else queue the three currents
  function automatic void absorb_sample_set(in_item_t s);
    out_item_t r;
    if (cal_open) begin
      code_sum[0] += s.sample_a;
      code_sum[1] += s.sample_b;
      // phase c only counts on sets that arrive in three-phase mode
      if (three_phase) code_sum[2] += s.sample_c;
      cal_sets++;
      if (cal_sets >= CalSets) begin
        for (int k = 0; k < 3; k++) code_offset[k] = (code_sum[k] * 16) / CalSets;
        cal_open = 1'b0;
      end
    end else begin
      r.current_a = scaled_current(s.sample_a, code_offset[0], phase_neg[0]);
      r.current_b = scaled_current(s.sample_b, code_offset[1], phase_neg[1]);
      r.current_c = three_phase ? scaled_current(s.sample_c, code_offset[2], phase_neg[2])
                                : '0;
      currents_due.push_back(r);
    end
  endfunction

  // driver: offers the next pending set, holds it until the block takes it
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        absorb_sample_set(in_data_i);
        items_sent <= items_sent + 1;
      end
      // slot is free when nothing is offered or the offer was just taken
      if (!in_valid_i || in_ready_o) begin
        if (sets_pending.size() != 0 && (tx_calm || $urandom_range(99) >= IdlePct)) begin
          in_valid_i <= 1'b1;
          in_data_i  <= sets_pending.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off, and a calm stretch
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (!hold_done && currents_seen == HoldAtResult) begin
      out_ready_i <= 1'b0;
      hold_left   <= HoldCycles;
      hold_done   <= 1'b1;
    end else begin
      out_ready_i <= rx_calm || $urandom_range(99) >= IdlePct;
    end
  end

  task automatic check_field(string name, logic signed [CurW-1:0] got,
                             logic signed [CurW-1:0] want);
    if (got !== want)
      flag_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // monitor: each accepted result against the oldest owed one
  out_item_t want_now;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      currents_seen <= currents_seen + 1;
      if (currents_due.size() == 0) begin
        flag_mismatch("result with no request owing one");
      end else begin
        want_now = currents_due.pop_front();
        check_field("current_a", out_data_o.current_a, want_now.current_a);
        check_field("current_b", out_data_o.current_b, want_now.current_b);
        check_field("current_c", out_data_o.current_c, want_now.current_c);
      end
    end
  end

  // register write, predictor copy follows on acceptance
  task automatic write_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgChannelMode:  three_phase  = val[0];
      CfgSignPhaseA:   phase_neg[0] = val[0];
      CfgSignPhaseB:   phase_neg[1] = val[0];
      CfgSignPhaseC:   phase_neg[2] = val[0];
      CfgCurrentScale: scale_q12    = val;
      default: ;
    endcase
  endtask

  // one-bit registers get junk in the upper bits, only bit zero counts
  task automatic write_flag(logic [CfgAddrW-1:0] idx, bit b);
    write_reg(idx, {(CfgDataW - 1)'($urandom()), b});
  endtask

  task automatic setup(bit mode, bit [2:0] neg, logic [ScaleW-1:0] scale);
    write_flag(CfgChannelMode, mode);
    write_flag(CfgSignPhaseA, neg[0]);
    write_flag(CfgSignPhaseB, neg[1]);
    write_flag(CfgSignPhaseC, neg[2]);
    write_reg(CfgCurrentScale, scale);
  endtask

  // wait until every set is taken and every current has come, then let the block go quiet
  task automatic settle();
    while (sets_pending.size() != 0 || in_valid_i || currents_due.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // calibration sets: phase a near zero and phase b near full scale so the
  // offsets sit at both ends, phase c anywhere
  task automatic push_cal_sets(int unsigned n);
    in_item_t s;
    for (int unsigned i = 0; i < n; i++) begin
      s.sample_a = 12'($urandom_range(0, 7));
      s.sample_b = 12'($urandom_range(4088, 4095));
      s.sample_c = 12'($urandom());
      sets_pending.push_back(s);
    end
  endtask

  // all-zero, all-ones and the two checkerboards
  task automatic push_extremes();
    sets_pending.push_back('{12'h000, 12'h000, 12'h000});
    sets_pending.push_back('{12'hFFF, 12'hFFF, 12'hFFF});
    sets_pending.push_back('{12'hAAA, 12'h555, 12'hAAA});
    sets_pending.push_back('{12'h555, 12'hAAA, 12'h555});
  endtask

  function automatic logic [SampleBits-1:0] any_code();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return SampleBits'($urandom());
    endcase
  endfunction

  function automatic logic [ScaleW-1:0] any_scale();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return ScaleW'(1);
      2:       return '1;
      3:       return ScaleReset;
      4:       return ScaleW'($urandom_range(0, 65535));
      default: return ScaleW'($urandom());
    endcase
  endfunction

  initial begin
    in_item_t s;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // calibration in two-phase mode first, phase c must not be summed
    sets_pending.push_back('{12'h000, 12'hFFF, 12'hFFF});
    push_cal_sets(TwoPhaseCal - 1);
    settle();
    // mode flips mid-calibration, phase c offset from the later sets only
    write_flag(CfgChannelMode, 1'b1);
    push_cal_sets(CalSets - TwoPhaseCal);
    // queued right behind calibration, the first one meets freshly taken offsets
    push_extremes();
    settle();

    write_reg(UnusedIdx, CfgDataW'($urandom()));
    setup(1'b1, 3'b111, '1);
    push_extremes();
    settle();
    setup(1'b0, 3'b101, ScaleW'(1));
    push_extremes();
    settle();
    setup(1'b1, 3'b010, '0);
    push_extremes();
    settle();

    // random rounds, each under a fresh register setting
    for (int unsigned r = 0; r < Rounds; r++) begin
      setup(1'($urandom()), 3'($urandom()), any_scale());
      for (int unsigned i = 0; i < RoundSets; i++) begin
        s.sample_a = any_code();
        s.sample_b = any_code();
        s.sample_c = any_code();
        sets_pending.push_back(s);
      end
      settle();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #200000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
sv/pcs_pkg.sv
sv/pcs_calib.sv
sv/pcs_scale.sv
sv/phase_current_sense_calibrated_core.sv
sv/pcs_checker.sv
tb/phase_current_sense_calibrated_core_tb.sv
